// ===== sv/mbe_pkg.sv =====
// shared types, constants and helpers for the mandelbrot escape-time block
// no dependencies; imported by every module of the block
package mbe_pkg;

   localparam int unsigned Q_FRAC   = 28;
   localparam int unsigned MAX_ITER = 1000;
   localparam int unsigned ITER_W   = 10;
   localparam int unsigned MAX_DIM  = 4096;
   localparam int unsigned DIM_W    = 13;
   localparam int unsigned COORD_W  = 12;
   localparam int unsigned INDEX_W  = 24;
   localparam int unsigned ADDR_W   = 5;

   // 4.0 in q4.28
   localparam logic signed [36:0] ESC_LIMIT = 37'sd1073741824;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;

   // register indexes
   localparam logic [2:0] REG_CORNER_RE = 3'd0;
   localparam logic [2:0] REG_CORNER_IM = 3'd1;
   localparam logic [2:0] REG_STEP_RE   = 3'd2;
   localparam logic [2:0] REG_STEP_IM   = 3'd3;
   localparam logic [2:0] REG_WIDTH     = 3'd4;
   localparam logic [2:0] REG_HEIGHT    = 3'd5;

   localparam logic [31:0] RST_CORNER_RE = 32'hE000_0000;
   localparam logic [31:0] RST_CORNER_IM = 32'hE800_0000;
   localparam logic [31:0] RST_STEP      = 32'h0003_0031;

   typedef struct packed {
      logic signed [31:0] corner_re;
      logic signed [31:0] corner_im;
      logic signed [31:0] step_re;
      logic signed [31:0] step_im;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
   } mbe_cfg_type;

   // one classified request waiting for the iteration engine
   typedef struct packed {
      logic signed [31:0] c_re;
      logic signed [31:0] c_im;
      logic [INDEX_W-1:0] pixel_index;
      logic               out_of_range;
   } mbe_job_type;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_MUL,
      CORE_UPD,
      CORE_DONE
   } mbe_core_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
      logic signed [31:0] r;
      if (v > 46'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -46'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = signed'(v[31:0]);
      end
      return r;
   endfunction

endpackage

// ===== sv/mbe_front.sv =====
// front end: takes requests, checks the grid bounds, forms c and the pixel index
// depends on mbe_pkg; feeds mbe_queue
module mbe_front (
   input  logic                            clock,
   input  logic                            reset,
   input  mbe_pkg::mbe_cfg_type            cfg,
   input  logic                            req_valid,
   input  logic [mbe_pkg::COORD_W-1:0]     req_column,
   input  logic [mbe_pkg::COORD_W-1:0]     req_row,
   output logic                            req_stall,
   output logic                            push,
   output mbe_pkg::mbe_job_type            push_job,
   input  logic                            queue_full
);
   import mbe_pkg::*;

   logic                     hold_valid_ff, hold_valid_in;
   logic signed [44:0]       prod_re_ff, prod_re_in;
   logic signed [44:0]       prod_im_ff, prod_im_in;
   logic [INDEX_W-1:0]       index_ff, index_in;
   logic                     oor_ff, oor_in;
   logic                     accept;
   logic [DIM_W-1:0]         w_eff, h_eff;
   logic [24:0]              row_times_w;
   logic signed [45:0]       sum_re, sum_im;

   assign req_stall = hold_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = hold_valid_ff && !queue_full;

   always_comb begin
      w_eff = (cfg.width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.width;
      h_eff = (cfg.height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.height;
      oor_in = ({1'b0, req_column} >= w_eff) || ({1'b0, req_row} >= h_eff);
      row_times_w = 25'(req_row) * 25'(w_eff);
      index_in = oor_in ? '0 : INDEX_W'(row_times_w + 25'(req_column));
      prod_re_in = 45'(cfg.step_re) * 45'(signed'({1'b0, req_column}));
      prod_im_in = 45'(cfg.step_im) * 45'(signed'({1'b0, req_row}));
      hold_valid_in = accept ? 1'b1 : (push ? 1'b0 : hold_valid_ff);
   end

   always_comb begin
      sum_re = 46'(cfg.corner_re) + 46'(prod_re_ff);
      sum_im = 46'(cfg.corner_im) + 46'(prod_im_ff);
      push_job.c_re         = sat32(sum_re);
      push_job.c_im         = sat32(sum_im);
      push_job.pixel_index  = index_ff;
      push_job.out_of_range = oor_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_re_ff <= prod_re_in;
         prod_im_ff <= prod_im_in;
         index_ff   <= index_in;
         oor_ff     <= oor_in;
      end
   end

endmodule

// ===== sv/mbe_queue.sv =====
// short queue of classified requests between the front end and the engine
// depends on mbe_pkg
module mbe_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mbe_pkg::mbe_job_type  push_job,
   output logic                  full,
   input  logic                  pop,
   output mbe_pkg::mbe_job_type  pop_job,
   output logic                  empty
);
   import mbe_pkg::*;

   mbe_job_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/mbe_core.sv =====
// iteration engine: runs z = z*z + c on one request and holds the result
// depends on mbe_pkg; drains mbe_queue and drives the response channel
module mbe_core (
   input  logic                         clock,
   input  logic                         reset,
   input  mbe_pkg::mbe_job_type         pop_job,
   input  logic                         queue_empty,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mbe_pkg::INDEX_W-1:0]  rsp_pixel_index,
   output logic [mbe_pkg::ITER_W-1:0]   rsp_iterations,
   output logic                         rsp_out_of_range
);
   import mbe_pkg::*;

   mbe_core_state_type   state_ff, state_in;
   logic signed [31:0]   cre_ff, cre_in, cim_ff, cim_in;
   logic signed [31:0]   x_ff, x_in, y_ff, y_in;
   logic signed [63:0]   pxx_ff, pxx_in, pyy_ff, pyy_in, pxy_ff, pxy_in;
   logic [ITER_W-1:0]    it_ff, it_in;
   logic                 tested_ff, tested_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [ITER_W-1:0]    res_iter_ff, res_iter_in;
   logic                 res_oor_ff, res_oor_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]   rsp_index_ff;
   logic [ITER_W-1:0]    rsp_iter_ff;
   logic                 rsp_oor_ff;
   logic                 load_rsp;
   logic signed [35:0]   sq_re, sq_im;
   logic signed [36:0]   xy2, mag;
   logic                 escaped;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_index  = rsp_index_ff;
   assign rsp_iterations   = rsp_iter_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   always_comb begin
      // truncated squares and doubled cross product of the current point
      sq_re   = signed'(pxx_ff[63:28]);
      sq_im   = signed'(pyy_ff[63:28]);
      xy2     = signed'(pxy_ff[63:27]);
      mag     = 37'(sq_re) + 37'(sq_im);
      escaped = tested_ff && (mag > ESC_LIMIT);

      state_in    = state_ff;
      cre_in      = cre_ff;
      cim_in      = cim_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      pxx_in      = pxx_ff;
      pyy_in      = pyy_ff;
      pxy_in      = pxy_ff;
      it_in       = it_ff;
      tested_in   = tested_ff;
      idx_in      = idx_ff;
      res_iter_in = res_iter_ff;
      res_oor_in  = res_oor_ff;
      pop         = 1'b0;
      load_rsp    = 1'b0;

      case (state_ff)
         CORE_IDLE: begin
            if (!queue_empty) begin
               pop       = 1'b1;
               cre_in    = pop_job.c_re;
               cim_in    = pop_job.c_im;
               x_in      = pop_job.c_re;
               y_in      = pop_job.c_im;
               idx_in    = pop_job.pixel_index;
               it_in     = '0;
               tested_in = 1'b0;
               if (pop_job.out_of_range) begin
                  res_iter_in = '0;
                  res_oor_in  = 1'b1;
                  state_in    = CORE_DONE;
               end else begin
                  res_oor_in = 1'b0;
                  state_in   = CORE_MUL;
               end
            end
         end
         CORE_MUL: begin
            pxx_in   = x_ff * x_ff;
            pyy_in   = y_ff * y_ff;
            pxy_in   = x_ff * y_ff;
            state_in = CORE_UPD;
         end
         CORE_UPD: begin
            if (escaped) begin
               res_iter_in = it_ff;
               state_in    = CORE_DONE;
            end else if (tested_ff && (it_ff == ITER_W'(MAX_ITER - 1))) begin
               res_iter_in = ITER_W'(MAX_ITER);
               state_in    = CORE_DONE;
            end else begin
               x_in      = sat32(46'(sq_re) - 46'(sq_im) + 46'(cre_ff));
               y_in      = sat32(46'(xy2) + 46'(cim_ff));
               it_in     = tested_ff ? it_ff + 1'b1 : it_ff;
               tested_in = 1'b1;
               state_in  = CORE_MUL;
            end
         end
         CORE_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = CORE_IDLE;
            end
         end
         default: begin
            state_in = CORE_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CORE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cre_ff      <= cre_in;
      cim_ff      <= cim_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      pxx_ff      <= pxx_in;
      pyy_ff      <= pyy_in;
      pxy_ff      <= pxy_in;
      it_ff       <= it_in;
      tested_ff   <= tested_in;
      idx_ff      <= idx_in;
      res_iter_ff <= res_iter_in;
      res_oor_ff  <= res_oor_in;
      if (load_rsp) begin
         rsp_index_ff <= idx_ff;
         rsp_iter_ff  <= res_iter_ff;
         rsp_oor_ff   <= res_oor_ff;
      end
   end

endmodule

// ===== sv/mandelbrot_escape_time.sv =====
// mandelbrot escape-time block: registers, front end, request queue, iteration engine
// path of a request with no stall: front end register, queue, engine load, then passes of
// CORE_MUL (32x32 products) and CORE_UPD (add, saturate and escape compare) until the pixel
// escapes or reaches MAX_ITER, then CORE_DONE and the output register; the engine takes
// one pixel at a time and pops the next only after loading the last; out-of-grid skips the passes
// reset: synchronous; clears the queue and all handshakes and loads the register defaults
module mandelbrot_escape_time (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [mbe_pkg::COORD_W-1:0]    req_column,
   input  logic [mbe_pkg::COORD_W-1:0]    req_row,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mbe_pkg::INDEX_W-1:0]    rsp_pixel_index,
   output logic [mbe_pkg::ITER_W-1:0]     rsp_iterations,
   output logic                           rsp_out_of_range,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mbe_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import mbe_pkg::*;

   mbe_cfg_type   cfg_ff, cfg_in;
   logic          csr_write;
   logic [2:0]    reg_index;
   logic          push, queue_full, pop, queue_empty;
   mbe_job_type   push_job, pop_job;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            REG_CORNER_RE: cfg_in.corner_re = signed'(csr_pwdata);
            REG_CORNER_IM: cfg_in.corner_im = signed'(csr_pwdata);
            REG_STEP_RE:   cfg_in.step_re   = signed'(csr_pwdata);
            REG_STEP_IM:   cfg_in.step_im   = signed'(csr_pwdata);
            REG_WIDTH:     cfg_in.width     = csr_pwdata[DIM_W-1:0];
            REG_HEIGHT:    cfg_in.height    = csr_pwdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_CORNER_RE: csr_prdata = cfg_ff.corner_re;
         REG_CORNER_IM: csr_prdata = cfg_ff.corner_im;
         REG_STEP_RE:   csr_prdata = cfg_ff.step_re;
         REG_STEP_IM:   csr_prdata = cfg_ff.step_im;
         REG_WIDTH:     csr_prdata = 32'(cfg_ff.width);
         REG_HEIGHT:    csr_prdata = 32'(cfg_ff.height);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.corner_re <= signed'(RST_CORNER_RE);
         cfg_ff.corner_im <= signed'(RST_CORNER_IM);
         cfg_ff.step_re   <= signed'(RST_STEP);
         cfg_ff.step_im   <= signed'(RST_STEP);
         cfg_ff.width     <= DIM_W'(MAX_DIM);
         cfg_ff.height    <= DIM_W'(MAX_DIM);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_column (req_column),
      .req_row    (req_row),
      .req_stall  (req_stall),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   mbe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   mbe_core u_core (
      .clock            (clock),
      .reset            (reset),
      .pop_job          (pop_job),
      .queue_empty      (queue_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_index  (rsp_pixel_index),
      .rsp_iterations   (rsp_iterations),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

// ===== tb/mbe_checker.sv =====
// result checker for the mandelbrot escape-time block: snoops the register port and both
// channels, predicts each accepted request and compares the results in order
// depends on mbe_pkg
module mbe_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [mbe_pkg::COORD_W-1:0]  req_column,
   input  logic [mbe_pkg::COORD_W-1:0]  req_row,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [mbe_pkg::INDEX_W-1:0]  rsp_pixel_index,
   input  logic [mbe_pkg::ITER_W-1:0]   rsp_iterations,
   input  logic                         rsp_out_of_range,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic                         csr_pready,
   input  logic [mbe_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output int unsigned                  failures,
   output int unsigned                  pending
);
   import mbe_pkg::*;

   // 4.0 in q4.28
   localparam logic signed [63:0] ESCAPE_SUM = 64'sd1073741824;

   typedef struct {
      logic [INDEX_W-1:0] pixel_index;
      logic [ITER_W-1:0]  iterations;
      logic               out_of_range;
   } pixel_result_type;

   mbe_cfg_type      view;
   pixel_result_type expected_pixels[$];
   int unsigned      mismatches = 0;

   function automatic logic signed [31:0] clamp_q428(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic [ITER_W-1:0] escape_iterations(input logic signed [31:0] c_re,
                                                            input logic signed [31:0] c_im);
      logic signed [63:0] x, y, xx, yy, xy2, re0, im0;
      int unsigned n;
      re0 = c_re;
      im0 = c_im;
      x = re0;
      y = im0;
      for (n = 0; n < MAX_ITER; n++) begin
         xx = (x * x) >>> Q_FRAC;
         yy = (y * y) >>> Q_FRAC;
         // doubled cross term: one bit less of shift
         xy2 = (x * y) >>> (Q_FRAC - 1);
         x = clamp_q428(xx - yy + re0);
         y = clamp_q428(xy2 + im0);
         if (((x * x) >>> Q_FRAC) + ((y * y) >>> Q_FRAC) > ESCAPE_SUM) return ITER_W'(n);
      end
      return ITER_W'(MAX_ITER);
   endfunction

   function automatic pixel_result_type predict_pixel(input logic [COORD_W-1:0] col,
                                                      input logic [COORD_W-1:0] row);
      pixel_result_type r;
      longint unsigned w, h;
      logic signed [31:0] c_re, c_im;
      w = (view.width > MAX_DIM) ? MAX_DIM : view.width;
      h = (view.height > MAX_DIM) ? MAX_DIM : view.height;
      if (col >= w || row >= h) begin
         r.pixel_index = '0;
         r.iterations = '0;
         r.out_of_range = 1'b1;
      end else begin
         c_re = clamp_q428(64'(view.corner_re) + 64'(view.step_re) * $signed({52'd0, col}));
         c_im = clamp_q428(64'(view.corner_im) + 64'(view.step_im) * $signed({52'd0, row}));
         r.pixel_index = INDEX_W'(col + row * w);
         r.iterations = escape_iterations(c_re, c_im);
         r.out_of_range = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         view.corner_re = RST_CORNER_RE;
         view.corner_im = RST_CORNER_IM;
         view.step_re = RST_STEP;
         view.step_im = RST_STEP;
         view.width = DIM_W'(MAX_DIM);
         view.height = DIM_W'(MAX_DIM);
         expected_pixels.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_CORNER_RE: view.corner_re = csr_pwdata;
               REG_CORNER_IM: view.corner_im = csr_pwdata;
               REG_STEP_RE:   view.step_re = csr_pwdata;
               REG_STEP_IM:   view.step_im = csr_pwdata;
               REG_WIDTH:     view.width = csr_pwdata[DIM_W-1:0];
               REG_HEIGHT:    view.height = csr_pwdata[DIM_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_pixels.push_back(predict_pixel(req_column, req_row));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("result with no request waiting: pixel_index %0d iterations %0d",
                      rsp_pixel_index, rsp_iterations);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_index !== want.pixel_index) begin
                  $error("pixel_index: expected %0d, got %0d", want.pixel_index,
                         rsp_pixel_index);
                  mismatches++;
               end
               if (rsp_iterations !== want.iterations) begin
                  $error("iterations: expected %0d, got %0d", want.iterations,
                         rsp_iterations);
                  mismatches++;
               end
               if (rsp_out_of_range !== want.out_of_range) begin
                  $error("out_of_range: expected %0b, got %0b", want.out_of_range,
                         rsp_out_of_range);
                  mismatches++;
               end
            end
         end
      end
      failures <= mismatches;
      pending <= expected_pixels.size();
   end

endmodule

// ===== tb/testbench.sv =====
// top of the mandelbrot escape-time testbench: clock, reset, register setup and pixel
// requests with random idling; depends on mbe_pkg, mandelbrot_escape_time and mbe_checker
module testbench;
   import mbe_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 6_000_000;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned LONG_HOLD     = 400;
   localparam logic [2:0]  UNMAPPED_REG_A = 3'd6;
   localparam logic [2:0]  UNMAPPED_REG_B = 3'd7;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic [COORD_W-1:0]  req_column = '0;
   logic [COORD_W-1:0]  req_row = '0;
   logic                req_stall;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [INDEX_W-1:0]  rsp_pixel_index;
   logic [ITER_W-1:0]   rsp_iterations;
   logic                rsp_out_of_range;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   int unsigned failures;
   int unsigned pending;
   int unsigned cycle_count = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_done = 0;
   int unsigned stall_left = 0;
   logic        quiet = 1'b0;

   mandelbrot_escape_time uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_column       (req_column),
      .req_row          (req_row),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_index  (rsp_pixel_index),
      .rsp_iterations   (rsp_iterations),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   mbe_checker pixel_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_column       (req_column),
      .req_row          (req_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_index  (rsp_pixel_index),
      .rsp_iterations   (rsp_iterations),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_pready       (csr_pready),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .failures         (failures),
      .pending          (pending)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: a random hold-off after each accepted result, plus one long hold on demand
   always @(posedge clock) begin
      int unsigned gap;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (holds_done != hold_requests) begin
         holds_done <= holds_done + 1;
         stall_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end else if (rsp_valid && !rsp_stall) begin
         gap = quiet ? 0 : $urandom_range(0, 4);
         stall_left <= gap;
         rsp_stall <= (gap > 0);
      end
   end

   task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_column <= col;
      req_row <= row;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic configure(input logic [31:0] cr, input logic [31:0] ci,
                            input logic [31:0] sr, input logic [31:0] si,
                            input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      csr_write(REG_CORNER_RE, cr);
      csr_write(REG_CORNER_IM, ci);
      csr_write(REG_STEP_RE, sr);
      csr_write(REG_STEP_IM, si);
      csr_write(REG_WIDTH, 32'(w));
      csr_write(REG_HEIGHT, 32'(h));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // stop offering and let every outstanding request come back
   task automatic finish_phase();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int draw_extent();
      case ($urandom_range(0, 4))
         0: return $urandom_range(1, 16);
         1: return $urandom_range(17, 512);
         2: return $urandom_range(513, 4096);
         3: return 4096;
         default: return 8191;
      endcase
   endfunction

   // mostly inside the grid, some at its edge, some anywhere
   function automatic logic [COORD_W-1:0] pick_coord(input int span);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return COORD_W'($urandom);
      if (roll == 1) return COORD_W'(span - 1 + $urandom_range(0, 1));
      return COORD_W'($urandom_range(0, span - 1));
   endfunction

   initial begin
      int w, h, span_w, span_h;
      logic [31:0] cr, ci, sr, si;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // default view of the whole set
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(2731, 2048);
      send_pixel(2048, 2048);
      send_pixel(4095, 0);
      send_pixel(0, 4095);
      send_pixel(12'hAAA, 12'h555);
      send_pixel(12'h555, 12'hAAA);
      finish_phase();

      // single-pixel grid; unmapped register writes must change nothing
      csr_write(UNMAPPED_REG_A, 32'hFFFF_FFFF);
      csr_write(UNMAPPED_REG_B, 32'h0000_0001);
      configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1);
      send_pixel(0, 0);
      send_pixel(1, 0);
      send_pixel(0, 1);
      send_pixel(4095, 4095);
      finish_phase();

      // extreme corner and step: c saturates both ways; long hold fills the block
      configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 4096, 4096);
      send_pixel(1, 1);
      send_pixel(0, 0);
      send_pixel(2, 1);
      send_pixel(4095, 4095);
      hold_requests <= hold_requests + 1;
      repeat (40) send_pixel(COORD_W'($urandom), COORD_W'($urandom));
      finish_phase();

      // zero width with oversized height: nothing is inside
      configure(RST_CORNER_RE, RST_CORNER_IM, RST_STEP, RST_STEP, 0, 8191);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(0, 4095);
      finish_phase();

      // oversized grid clamps to the largest; last pixel gives the top index
      configure(RST_CORNER_RE, RST_CORNER_IM, RST_STEP, RST_STEP, 8191, 8191);
      send_pixel(4095, 4095);
      send_pixel(0, 0);
      send_pixel(2731, 2048);
      send_pixel(4095, 0);
      finish_phase();

      // zoom near the boundary: wide spread of iteration counts
      configure(-209379655, 26843546, 209715, 209715, 64, 64);
      repeat (40) send_pixel(pick_coord(64), pick_coord(64));
      finish_phase();

      for (int p = 0; p < 6; p++) begin
         w = draw_extent();
         h = draw_extent();
         span_w = (w > 4096) ? 4096 : w;
         span_h = (h > 4096) ? 4096 : h;
         // window of about 3.0 by 3.0 around the set
         sr = 805306368 / span_w + $urandom_range(0, 4095);
         si = 805306368 / span_h + $urandom_range(0, 4095);
         cr = -671088640 + $urandom_range(0, 134217728);
         ci = -469762048 + $urandom_range(0, 134217728);
         if (p == 3) begin
            // mirrored: walk from the far corner with negative steps
            cr = 268435456 + $urandom_range(0, 134217728);
            ci = -ci;
            sr = -sr;
            si = -si;
         end
         configure(cr, ci, sr, si, DIM_W'(w), DIM_W'(h));
         quiet <= (p == 1);
         repeat (90) send_pixel(pick_coord(span_w), pick_coord(span_h));
         finish_phase();
      end

      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
